### rtl/mwa_pkg.sv
// Shared types, widths and codes of the mirrored window average block.
package mwa_pkg;

  localparam int COL_W      = 12;
  localparam int SCORE_W    = 16;
  localparam int HW_W       = 11;
  localparam int NC_W       = 13;
  localparam int WIN_W      = HW_W + 1;
  localparam int SUM_W      = SCORE_W + WIN_W;
  localparam int IDX_W      = NC_W + 2;
  localparam int ADDR_EXT_W = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = NC_W;

  localparam int DEF_MAX_COLUMNS     = 4096;
  localparam int DEF_MAX_HALF_WINDOW = 1024;

  localparam logic [NC_W-1:0] RESET_NUM_COLUMNS = NC_W'(4096);

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLUMNS = 1'b1;

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_WAIT,
    ST_START,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

### rtl/mwa_if.sv
// Valid/ready channel interfaces for the input items and the result items.
interface mwa_in_if import mwa_pkg::*;;
  logic               valid;
  logic               ready;
  logic [0:0]         operation;
  logic [COL_W-1:0]   column;
  logic [SCORE_W-1:0] score_in;

  modport source (output valid, output operation, output column, output score_in,
                  input ready);
  modport sink   (input valid, input operation, input column, input score_in,
                  output ready);
endinterface

interface mwa_out_if import mwa_pkg::*;;
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] windowed_score;
  logic               window_too_big;

  modport source (output valid, output windowed_score, output window_too_big,
                  input ready);
  modport sink   (input valid, input windowed_score, input window_too_big,
                  output ready);
endinterface

### rtl/mwa_store.sv
// Column score memory: one write port, one registered read port.
module mwa_store import mwa_pkg::*; #(
  parameter int DEPTH = DEF_MAX_COLUMNS,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AddrW-1:0]   waddr,
  input  logic [SCORE_W-1:0] wdata,
  input  logic               re,
  input  logic [AddrW-1:0]   raddr,
  output logic [SCORE_W-1:0] rdata
);

  logic [SCORE_W-1:0] mem [DEPTH];
  logic [SCORE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/mwa_div.sv
// Restoring divider, one quotient bit per cycle, for sums below divisor * 2^16.
module mwa_div import mwa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SUM_W-1:0]   dividend,
  input  logic [WIN_W-1:0]   divisor,
  output logic               done,
  output logic [SCORE_W-1:0] quotient
);

  localparam int CntW = $clog2(SCORE_W + 1);

  logic [WIN_W-1:0]   rem_r;
  logic [SCORE_W-1:0] dq_r;
  logic [CntW-1:0]    cnt_r;
  logic               done_r;

  logic [WIN_W:0]     trial;
  logic [WIN_W:0]     diff;
  logic               fits;
  logic [WIN_W-1:0]   rem_step;

  always_comb begin
    trial    = {rem_r, dq_r[SCORE_W-1]};
    diff     = trial - {1'b0, divisor};
    fits     = (trial >= {1'b0, divisor});
    rem_step = fits ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= dividend[SUM_W-1:SCORE_W];
        dq_r  <= dividend[SCORE_W-1:0];
        cnt_r <= CntW'(SCORE_W);
      end else if (cnt_r != '0) begin
        rem_r  <= rem_step;
        dq_r   <= {dq_r[SCORE_W-2:0], fits};
        cnt_r  <= cnt_r - CntW'(1);
        done_r <= (cnt_r == CntW'(1));
      end
    end
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

### rtl/mirrored_window_average.sv
// Mirror-padded moving average over a column score memory.
// Load: writes the score, no result; the next item is taken in the following cycle.
// Query: 2h+1 memory reads, one per cycle, then the divider; a window-too-big query skips
// the reads and the divider and gives its result directly.
// No new item is taken until a query's result is moved into the output register.
// Reset (synchronous, rst_n low) clears control, sets h=0 and n=4096; memory is not cleared.
module mirrored_window_average import mwa_pkg::*; #(
  parameter int MAX_COLUMNS     = DEF_MAX_COLUMNS,
  parameter int MAX_HALF_WINDOW = DEF_MAX_HALF_WINDOW
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mwa_in_if.sink                in_ch,
  mwa_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AddrW = $clog2(MAX_COLUMNS);

  state_t                    state_r, state_nxt;
  logic [HW_W-1:0]           half_window_r;
  logic [NC_W-1:0]           num_columns_r;
  logic signed [IDX_W-1:0]   j_r, j_nxt;
  logic [WIN_W-1:0]          cnt_r, cnt_nxt;
  logic [WIN_W-1:0]          win_r, win_nxt;
  logic [SUM_W-1:0]          sum_r, sum_nxt;
  logic                      rd_pend_r, rd_pend_nxt;
  logic [SCORE_W-1:0]        res_score_r, res_score_nxt;
  logic                      res_err_r, res_err_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [SCORE_W-1:0]        out_score_r, out_score_nxt;
  logic                      out_err_r, out_err_nxt;

  logic                      in_ready;
  logic                      in_acc;
  logic [NC_W-1:0]           n_eff;
  logic                      too_big;
  logic [COL_W-1:0]          col_q;
  logic signed [IDX_W-1:0]   j_start;
  logic signed [IDX_W-1:0]   n_s;
  logic signed [IDX_W-1:0]   k;
  logic [ADDR_EXT_W-1:0]     k_ext;
  logic [ADDR_EXT_W-1:0]     wcol_ext;
  logic                      load_in_range;
  logic                      st_we;
  logic                      st_re;
  logic [SCORE_W-1:0]        rd_data;
  logic                      div_start;
  logic                      div_done;
  logic [SCORE_W-1:0]        quotient;

  always_comb begin
    if (num_columns_r == '0) begin
      n_eff = NC_W'(1);
    end else if (32'(num_columns_r) > MAX_COLUMNS) begin
      n_eff = NC_W'(MAX_COLUMNS);
    end else begin
      n_eff = num_columns_r;
    end
    too_big = (half_window_r > n_eff[NC_W-1:2]) ||
              (32'(half_window_r) > MAX_HALF_WINDOW);
    col_q   = ({1'b0, in_ch.column} >= n_eff) ? COL_W'(n_eff - NC_W'(1)) : in_ch.column;
    j_start = $signed({3'b000, col_q}) - $signed({4'b0000, half_window_r});
    n_s     = $signed({2'b00, n_eff});
    if (j_r < 0) begin
      k = -j_r;
    end else if (j_r >= n_s) begin
      k = n_s + n_s - j_r - 15'sd2;
    end else begin
      k = j_r;
    end
    k_ext         = {2'b00, k};
    wcol_ext      = {5'b00000, in_ch.column};
    load_in_range = (32'(in_ch.column) < MAX_COLUMNS);
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_ch.valid && in_ready;
  assign st_we     = in_acc && (in_ch.operation == OP_LOAD) && load_in_range;
  assign st_re     = (state_r == ST_SUM);
  assign div_start = (state_r == ST_START);

  mwa_store #(
    .DEPTH (MAX_COLUMNS)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (wcol_ext[AddrW-1:0]),
    .wdata (in_ch.score_in),
    .re    (st_re),
    .raddr (k_ext[AddrW-1:0]),
    .rdata (rd_data)
  );

  mwa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (win_r),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_nxt     = state_r;
    j_nxt         = j_r;
    cnt_nxt       = cnt_r;
    win_nxt       = win_r;
    res_score_nxt = res_score_r;
    res_err_nxt   = res_err_r;
    out_score_nxt = out_score_r;
    out_err_nxt   = out_err_r;
    rd_pend_nxt   = (state_r == ST_SUM);
    sum_nxt       = rd_pend_r ? (sum_r + SUM_W'(rd_data)) : sum_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_ch.operation == OP_QUERY)) begin
          if (too_big) begin
            res_score_nxt = '0;
            res_err_nxt   = 1'b1;
            state_nxt     = ST_DONE;
          end else begin
            j_nxt       = j_start;
            win_nxt     = {half_window_r, 1'b1};
            cnt_nxt     = {half_window_r, 1'b1};
            sum_nxt     = '0;
            res_err_nxt = 1'b0;
            state_nxt   = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        j_nxt   = j_r + 15'sd1;
        cnt_nxt = cnt_r - WIN_W'(1);
        if (cnt_r == WIN_W'(1)) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_nxt = ST_START;
      end
      ST_START: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          res_score_nxt = quotient;
          state_nxt     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_score_nxt = res_score_r;
          out_err_nxt   = res_err_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      rd_pend_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      half_window_r <= '0;
      num_columns_r <= RESET_NUM_COLUMNS;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_HALF_WINDOW: half_window_r <= cfg_data[HW_W-1:0];
          CFG_NUM_COLUMNS: num_columns_r <= cfg_data;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    j_r         <= j_nxt;
    cnt_r       <= cnt_nxt;
    win_r       <= win_nxt;
    sum_r       <= sum_nxt;
    res_score_r <= res_score_nxt;
    res_err_r   <= res_err_nxt;
    out_score_r <= out_score_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign in_ch.ready           = in_ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.windowed_score = out_score_r;
  assign out_ch.window_too_big = out_err_r;

endmodule

### rtl/mwa_checker.sv
// Port-level checks of the mirrored window average block, bound to the top level.
module mwa_checker import mwa_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [0:0]         in_operation,
  input logic               out_valid,
  input logic               out_ready,
  input logic [SCORE_W-1:0] out_windowed_score,
  input logic               out_window_too_big
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_windowed_score) &&
                                $stable(out_window_too_big))
    else $error("result item changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_window_too_big |-> out_windowed_score == '0)
    else $error("error result carries a nonzero score");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation == OP_LOAD) && !out_valid |=> !out_valid)
    else $error("load item produced a result");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation == OP_QUERY) |=> !in_ready)
    else $error("input taken while a query is in progress");

endmodule

bind mirrored_window_average mwa_checker u_mwa_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .in_operation       (in_ch.operation),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_windowed_score (out_ch.windowed_score),
  .out_window_too_big (out_ch.window_too_big)
);
